@@ src/pfx_pkg.sv @@
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared types, character codes and status codes of the postfix evaluator.
// ----------------------------------------------------------------------------
package pfx_pkg;

  // Fixed field widths
  localparam int VAL_W    = 48;
  localparam int HALF_W   = VAL_W / 2;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 4;
  localparam int STATUS_W = 3;
  localparam int SEL_W    = 2;

  // Saturation limits of a stack entry
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_FULL  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_SAT   = 3'd4,
    ST_EMPTY = 3'd5
  } status_t;

  // Arithmetic operations
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic               push;
    logic [DIGIT_W-1:0] digit;
    logic               note_full;
    logic               note_under;
    logic               rd_en;
    logic               load;
    logic               pop_zero;
    logic               add_res;
    op_t                op;
    logic               mul_pp;
    logic               mul_acc;
    logic [SEL_W-1:0]   mul_sel;
    logic               div_step;
    logic               wrap;
    logic               emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic under;
    logic t_zero;
    logic out_free;
  } dp_stat_t;

  // Magnitude of a signed entry (the most negative value maps to 2^(VAL_W-1))
  function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

@@ src/pfx_ram.sv @@
// ----------------------------------------------------------------------------
// pfx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfx_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/pfx_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfx_ctrl
// Sequencer: takes one character item, steps the datapath through the push,
// operand fetch, arithmetic and result emission.
// ----------------------------------------------------------------------------
module pfx_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [pfx_pkg::CHAR_W-1:0] in_char,
  input  logic                       in_last,
  output pfx_pkg::dp_cmd_t           cmd,
  input  pfx_pkg::dp_stat_t          stat
);

  localparam int DW = pfx_pkg::VAL_W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic [CW-1:0] MUL_LAST = CW'(4);
  localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_ADDSUB,
    S_MUL,
    S_DIV,
    S_WRAP,
    S_FINISH
  } state_t;

  state_t                     state_r, state_nxt;
  logic [pfx_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic                       last_r, last_nxt;
  pfx_pkg::op_t               op_r, op_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [pfx_pkg::CHAR_W-1:0] digit_full;

  assign digit_full = char_r - pfx_pkg::CH_ZERO;
  assign in_tready  = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = op_r;
    cmd.digit = digit_full[pfx_pkg::DIGIT_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          char_nxt  = in_char;
          last_nxt  = in_last;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        case (char_r) inside
          [pfx_pkg::CH_ZERO:pfx_pkg::CH_NINE]: begin
            if (stat.full) begin
              cmd.note_full = 1'b1;
            end else begin
              cmd.push = 1'b1;
            end
          end
          pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS, pfx_pkg::CH_STAR, pfx_pkg::CH_SLASH: begin
            case (char_r)
              pfx_pkg::CH_PLUS:  op_nxt = pfx_pkg::OP_ADD;
              pfx_pkg::CH_MINUS: op_nxt = pfx_pkg::OP_SUB;
              pfx_pkg::CH_STAR:  op_nxt = pfx_pkg::OP_MUL;
              default:           op_nxt = pfx_pkg::OP_DIV;
            endcase
            if (stat.under) begin
              cmd.note_under = 1'b1;
            end else begin
              cmd.rd_en = 1'b1;
              state_nxt = S_FETCH;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_FETCH: begin
        cmd.load = 1'b1;
        cnt_nxt  = '0;
        case (op_r)
          pfx_pkg::OP_ADD, pfx_pkg::OP_SUB: state_nxt = S_ADDSUB;
          pfx_pkg::OP_MUL:                  state_nxt = S_MUL;
          default: begin
            if (stat.t_zero) begin
              cmd.pop_zero = 1'b1;
              state_nxt    = S_FINISH;
            end else begin
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_ADDSUB: begin
        cmd.add_res = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_MUL: begin
        // Partial product issue overlaps the accumulation of the previous one
        cmd.mul_pp  = (cnt_r != MUL_LAST);
        cmd.mul_acc = (cnt_r != '0);
        cmd.mul_sel = cnt_r[pfx_pkg::SEL_W-1:0];
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = S_WRAP;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and sequencing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    char_r <= char_nxt;
    last_r <= last_nxt;
    op_r   <= op_nxt;
  end

endmodule

@@ src/pfx_dpath.sv @@
// ----------------------------------------------------------------------------
// pfx_dpath
// Operand stack with cached top entry, adder, shared 24x24 multiplier,
// restoring divider, saturation and the result register.
// ----------------------------------------------------------------------------
module pfx_dpath #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfx_pkg::dp_cmd_t             cmd,
  output pfx_pkg::dp_stat_t            stat,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [pfx_pkg::VAL_W-1:0]    out_value,
  output logic [pfx_pkg::STATUS_W-1:0] out_status
);

  localparam int VW  = pfx_pkg::VAL_W;
  localparam int HW  = pfx_pkg::HALF_W;
  localparam int PW  = pfx_pkg::PROD_W;
  localparam int DW  = VW + FRAC_BITS;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam logic [PW-1:0] LIM_P = PW'(pfx_pkg::VAL_MAX);
  localparam logic [PW-1:0] LIM_N = LIM_P + 1'b1;

  logic [SPW-1:0]         sp_r, sp_nxt;
  pfx_pkg::status_t       err_r, err_nxt;
  logic [VW-1:0]          top_r, top_nxt;
  logic [VW-1:0]          s_r;
  logic [VW-1:0]          am_r;
  logic [VW-1:0]          bm_r;
  logic                   neg_r;
  logic [PW-1:0]          acc_r;
  logic [VW-1:0]          pp_r;
  logic [pfx_pkg::SEL_W-1:0] pps_r;
  logic [VW-1:0]          rem_r;
  logic [DW-1:0]          dq_r;
  logic                   out_valid_r;
  logic [VW-1:0]          out_value_r;
  pfx_pkg::status_t       out_status_r;

  logic [VW-1:0]          ram_rd;
  logic [SPW-1:0]         sp_m1;
  logic [SPW-1:0]         sp_m2;
  logic [VW-1:0]          s_mag;
  logic                   sp_zero;

  // Stack entries below the cached top
  assign sp_m1   = sp_r - SPW'(1);
  assign sp_m2   = sp_r - SPW'(2);
  assign sp_zero = (sp_r == '0);

  pfx_ram #(
    .WIDTH (VW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.push && !sp_zero),
    .wr_addr (sp_m1[AW-1:0]),
    .wr_data (top_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (sp_m2[AW-1:0]),
    .rd_data (ram_rd)
  );

  assign s_mag = pfx_pkg::mag(ram_rd);

  // Status toward the controller
  assign stat.full     = (sp_r >= SPW'(STACK_DEPTH));
  assign stat.under    = (sp_r < SPW'(2));
  assign stat.t_zero   = (top_r == '0);
  assign stat.out_free = !out_valid_r || out_tready;

  // Sum and difference with clamping
  logic [VW:0] sum;
  logic        sum_ovf;
  always_comb begin
    if (cmd.op == pfx_pkg::OP_SUB) begin
      sum = {s_r[VW-1], s_r} - {top_r[VW-1], top_r};
    end else begin
      sum = {s_r[VW-1], s_r} + {top_r[VW-1], top_r};
    end
    sum_ovf = (sum[VW] != sum[VW-1]);
  end

  // Partial product operands and accumulation shift
  function automatic logic [HW-1:0] pps_sel_a(input logic [pfx_pkg::SEL_W-1:0] sel,
                                              input logic [VW-1:0] v);
    return sel[0] ? v[VW-1:HW] : v[HW-1:0];
  endfunction

  function automatic logic [HW-1:0] pps_sel_b(input logic [pfx_pkg::SEL_W-1:0] sel,
                                              input logic [VW-1:0] v);
    return sel[1] ? v[VW-1:HW] : v[HW-1:0];
  endfunction

  logic [HW-1:0] pa, pb;
  logic [PW-1:0] pp_sh;
  assign pa = pps_sel_a(cmd.mul_sel, am_r);
  assign pb = pps_sel_b(cmd.mul_sel, bm_r);

  always_comb begin
    case (pps_r)
      2'd0:    pp_sh = PW'(pp_r);
      2'd3:    pp_sh = PW'(pp_r) << VW;
      default: pp_sh = PW'(pp_r) << HW;
    endcase
  end

  // Restoring division step
  logic [VW:0] r2;
  logic [VW:0] r2_diff;
  logic        q_bit;
  assign r2      = {rem_r, dq_r[DW-1]};
  assign r2_diff = r2 - {1'b0, bm_r};
  assign q_bit   = (r2 >= {1'b0, bm_r});

  // Saturating wrap-up of a product or quotient magnitude
  logic [PW-1:0] res_mag;
  logic          res_sat;
  logic [VW-1:0] res_val;
  always_comb begin
    if (cmd.op == pfx_pkg::OP_MUL) begin
      res_mag = acc_r >> FRAC_BITS;
    end else begin
      res_mag = PW'(dq_r);
    end
    res_sat = neg_r ? (res_mag > LIM_N) : (res_mag > LIM_P);
    if (res_sat) begin
      res_val = neg_r ? pfx_pkg::VAL_MIN : pfx_pkg::VAL_MAX;
    end else if (neg_r) begin
      res_val = VW'(0) - res_mag[VW-1:0];
    end else begin
      res_val = res_mag[VW-1:0];
    end
  end

  // Stack pointer, top entry and first error
  always_comb begin
    sp_nxt  = sp_r;
    top_nxt = top_r;
    err_nxt = err_r;
    if (cmd.push) begin
      sp_nxt  = sp_r + 1'b1;
      top_nxt = VW'(cmd.digit) << FRAC_BITS;
    end
    if (cmd.note_full && err_r == pfx_pkg::ST_OK) begin
      err_nxt = pfx_pkg::ST_FULL;
    end
    if (cmd.note_under && err_r == pfx_pkg::ST_OK) begin
      err_nxt = pfx_pkg::ST_UNDER;
    end
    if (cmd.pop_zero) begin
      sp_nxt  = sp_m1;
      top_nxt = '0;
      if (err_r == pfx_pkg::ST_OK) begin
        err_nxt = pfx_pkg::ST_DIVZ;
      end
    end
    if (cmd.add_res) begin
      sp_nxt = sp_m1;
      if (sum_ovf) begin
        top_nxt = sum[VW] ? pfx_pkg::VAL_MIN : pfx_pkg::VAL_MAX;
        if (err_r == pfx_pkg::ST_OK) begin
          err_nxt = pfx_pkg::ST_SAT;
        end
      end else begin
        top_nxt = sum[VW-1:0];
      end
    end
    if (cmd.wrap) begin
      sp_nxt  = sp_m1;
      top_nxt = res_val;
      if (res_sat && err_r == pfx_pkg::ST_OK) begin
        err_nxt = pfx_pkg::ST_SAT;
      end
    end
    if (cmd.emit) begin
      sp_nxt  = '0;
      err_nxt = pfx_pkg::ST_OK;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      err_r       <= pfx_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      sp_r  <= sp_nxt;
      err_r <= err_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand, multiplier, divider and result registers
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (cmd.load) begin
      s_r   <= ram_rd;
      am_r  <= s_mag;
      bm_r  <= pfx_pkg::mag(top_r);
      neg_r <= ram_rd[VW-1] ^ top_r[VW-1];
      acc_r <= '0;
      rem_r <= '0;
      dq_r  <= DW'(s_mag) << FRAC_BITS;
    end
    if (cmd.mul_pp) begin
      pp_r  <= pa * pb;
      pps_r <= cmd.mul_sel;
    end
    if (cmd.mul_acc) begin
      acc_r <= acc_r + pp_sh;
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? r2_diff[VW-1:0] : r2[VW-1:0];
      dq_r  <= {dq_r[DW-2:0], q_bit};
    end
    if (cmd.emit) begin
      out_value_r <= sp_zero ? '0 : top_r;
      if (err_r != pfx_pkg::ST_OK) begin
        out_status_r <= err_r;
      end else if (sp_zero) begin
        out_status_r <= pfx_pkg::ST_EMPTY;
      end else begin
        out_status_r <= pfx_pkg::ST_OK;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

@@ src/postfix_expression_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Postfix (RPN) evaluator over a character stream, signed fixed point.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                   | tuser        | tlast
//  in_     | in  | [7:0] char_code         | -            | end_of_text
//  out_    | out | [47:0] value (signed)   | [2:0] status | -
//
//  One item at a time. A multiply forms four 24x24 partial products on one
//  shared multiplier; a divide uses a restoring divider, one quotient bit per
//  cycle. A divide by zero does not run the divider.
//  Reset empties the stack and clears the recorded error.
//  The result sits in an output register; the next items are taken while it
//  waits, and a further end item holds until that result has been taken.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [47:0] value
  output logic [2:0]  out_tuser   // [2:0] status
);

  pfx_pkg::dp_cmd_t  cmd;
  pfx_pkg::dp_stat_t stat;

  // Sequencer
  pfx_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Stack and arithmetic
  pfx_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_tdata),
    .out_status (out_tuser)
  );

endmodule

@@ tb/pfx_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfx_checker
// Watches both streams of the postfix evaluator. Runs every accepted
// character through its own operand stack and compares each result item
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module pfx_checker #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [2:0]  out_tuser,
  output int unsigned mismatches,
  output int unsigned results_due,
  output int unsigned results_seen,
  output logic [7:0]  codes_seen
);
  import pfx_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    status_t          status;
  } eval_result_t;

  // Entry range held in a wide signed form
  localparam logic signed [127:0] WIDE_MAX = (128'sd1 <<< (VAL_W - 1)) - 128'sd1;
  localparam logic signed [127:0] WIDE_MIN = -(128'sd1 <<< (VAL_W - 1));

  logic [VAL_W-1:0] opnd [STACK_DEPTH];
  int unsigned      opnd_count;
  status_t          err_code;
  eval_result_t     eval_results_q[$];

  // Keep only the first error of an expression
  function automatic void record_error(status_t code);
    if (err_code == ST_OK) err_code = code;
  endfunction

  // Clamp an exact result into the entry range
  function automatic logic [VAL_W-1:0] clamp_entry(logic signed [127:0] r);
    if (r > WIDE_MAX) begin
      record_error(ST_SAT);
      return VAL_MAX;
    end
    if (r < WIDE_MIN) begin
      record_error(ST_SAT);
      return VAL_MIN;
    end
    return r[VAL_W-1:0];
  endfunction

  // Combine second entry s with top entry t; products and quotients truncate
  function automatic logic [VAL_W-1:0] apply_op(logic [7:0] c, logic [VAL_W-1:0] s,
                                                logic [VAL_W-1:0] t);
    logic signed [127:0] sw, tw, r;
    logic [127:0]        sm, tm, m;
    logic                neg;
    sw  = $signed(s);
    tw  = $signed(t);
    sm  = (sw < 0) ? -sw : sw;
    tm  = (tw < 0) ? -tw : tw;
    neg = (sw < 0) != (tw < 0);
    case (c)
      CH_PLUS:  r = sw + tw;
      CH_MINUS: r = sw - tw;
      CH_STAR: begin
        m = (sm * tm) >> FRAC_BITS;
        r = neg ? -$signed(m) : $signed(m);
      end
      default: begin
        if (tm == 0) begin
          record_error(ST_DIVZ);
          return '0;
        end
        m = (sm << FRAC_BITS) / tm;
        r = neg ? -$signed(m) : $signed(m);
      end
    endcase
    return clamp_entry(r);
  endfunction

  // Advance the predicted stack by one character
  task automatic eval_char(logic [7:0] c, logic last);
    eval_result_t res;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (opnd_count >= STACK_DEPTH) begin
        record_error(ST_FULL);
      end else begin
        opnd[opnd_count] = VAL_W'(c - CH_ZERO) << FRAC_BITS;
        opnd_count++;
      end
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      if (opnd_count < 2) begin
        record_error(ST_UNDER);
      end else begin
        opnd[opnd_count-2] = apply_op(c, opnd[opnd_count-2], opnd[opnd_count-1]);
        opnd_count--;
      end
    end
    if (last) begin
      if (opnd_count == 0) begin
        res.value  = '0;
        res.status = ST_EMPTY;
      end else begin
        res.value  = opnd[opnd_count-1];
        res.status = ST_OK;
      end
      if (err_code != ST_OK) res.status = err_code;
      eval_results_q.push_back(res);
      opnd_count = 0;
      err_code   = ST_OK;
    end
  endtask

  // Compare results first, then take the character of this edge
  always @(posedge clk) begin
    eval_result_t want;
    if (!rst_n) begin
      opnd_count   = 0;
      err_code     = ST_OK;
      mismatches   = 0;
      results_seen = 0;
      codes_seen   = '0;
      eval_results_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        codes_seen[out_tuser] = 1'b1;
        if (eval_results_q.size() == 0) begin
          mismatches++;
          $display("%0t: result item with none pending: value %h status %0d",
                   $time, out_tdata, out_tuser);
        end else begin
          want = eval_results_q.pop_front();
          if (out_tdata !== want.value) begin
            mismatches++;
            $display("%0t: value expected %h, got %h", $time, want.value, out_tdata);
          end
          if (out_tuser !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) eval_char(in_tdata, in_tlast);
    end
    results_due <= eval_results_q.size();
  end

endmodule

@@ tb/tb_postfix_expression_evaluator_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator_core
// Streams postfix expressions into the evaluator: a few directed ones, then
// random well-formed, broken, noise and stack-overflow expressions, with
// random gaps on both streams. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator_core;
  import pfx_pkg::*;

  localparam int ITEM_GOAL = 1150;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] char_code
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [47:0] value
  logic [2:0]  out_tuser;  // [2:0] status

  int unsigned mismatches, results_due, results_seen;
  logic [7:0]  codes_seen;
  int unsigned items_sent, exprs_sent;
  logic        steady;
  logic        paused;
  logic [7:0]  char_q[$];

  postfix_expression_evaluator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  pfx_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .mismatches   (mismatches),
    .results_due  (results_due),
    .results_seen (results_seen),
    .codes_seen   (codes_seen)
  );

  always #2 clk = ~clk;

  // Stall the result stream at random, except in the steady stretch
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 36);
  end

  // Watchdog
  initial begin
    #4000000;
    $display("watchdog expired with %0d results pending", results_due);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic is_active(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_STAR || c == CH_SLASH;
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit(int unsigned lo);
    return CH_ZERO + 8'($urandom_range(9, lo));
  endfunction

  function automatic logic [7:0] pick_noise();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (is_active(c)) c = 8'($urandom_range(255));
    return c;
  endfunction

  // Drive one item and hold it until accepted; called at a rising edge
  task automatic send_item(logic [7:0] c, logic last);
    if (!steady) begin
      while ($urandom_range(99) < 36) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (is_active(c) || last) items_sent++;
  endtask

  // Send the queued characters as one expression, end marked on the final one
  task automatic send_queue();
    for (int i = 0; i < char_q.size(); i++) send_item(char_q[i], i == char_q.size() - 1);
    char_q.delete();
    exprs_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
    send_queue();
  endtask

  // Hold the input stream until every pending result has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // Valid expression; the heavy flavor chains large products to saturate
  task automatic build_well_formed(logic heavy);
    int unsigned n_dig, pushed, popped;
    n_dig  = heavy ? $urandom_range(16, 10) : $urandom_range(8, 1);
    pushed = 0;
    popped = 0;
    while (pushed < n_dig || popped + 1 < n_dig) begin
      if ($urandom_range(99) < 5) char_q.push_back(pick_noise());
      if (pushed < n_dig && (pushed - popped < 2 || $urandom_range(1) == 1)) begin
        char_q.push_back(pick_digit(heavy ? 6 : 0));
        pushed++;
      end else begin
        char_q.push_back((heavy && $urandom_range(3) != 0) ? CH_STAR : pick_op());
        popped++;
      end
    end
  endtask

  // Random mix of digits and operators, often unbalanced
  task automatic build_broken();
    int unsigned len;
    len = $urandom_range(8, 1);
    repeat (len) char_q.push_back($urandom_range(1) ? pick_digit(0) : pick_op());
  endtask

  // Arbitrary bytes, mostly ignored
  task automatic build_noise();
    int unsigned len;
    len = $urandom_range(3, 1);
    repeat (len) char_q.push_back(8'($urandom_range(255)));
  endtask

  // Push 60 to 68 digits, up to past the stack depth, then fold one to four entries
  task automatic build_deep();
    int unsigned n_dig, n_op;
    n_dig = $urandom_range(68, 60);
    n_op  = $urandom_range(4, 1);
    repeat (n_dig) char_q.push_back(pick_digit(0));
    repeat (n_op) char_q.push_back(pick_op());
  endtask

  initial begin
    int unsigned roll;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    steady     = 1'b0;
    paused     = 1'b0;
    items_sent = 0;
    exprs_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: each operator, negative and fractional results, divide by
    // zero, ignored characters, underflow, empty stack, code extremes
    send_text("95+");
    send_text("09-");
    send_text("97/");
    send_text("90/");
    send_text("3 4*");
    send_text("+");
    send_text("#");
    char_q.push_back(8'h00);
    char_q.push_back(8'hFF);
    char_q.push_back(CH_ZERO + 8'd8);
    send_queue();
    drain_results();

    // Random expressions
    while (items_sent < ITEM_GOAL) begin
      roll = $urandom_range(99);
      if (roll < 70) build_well_formed(roll < 18);
      else if (roll < 85) build_broken();
      else if (roll < 97) build_noise();
      else build_deep();
      send_queue();
      steady <= (items_sent >= 300 && items_sent < 500);
      if (!paused && items_sent >= 700) begin
        drain_results();
        paused = 1'b1;
      end
    end

    // Let the last results out, then watch for strays
    drain_results();
    repeat (100) @(posedge clk);

    $display("Sent %0d counted items in %0d expressions (well-formed, broken, noise, overflow).",
             items_sent, exprs_sent);
    $display("Checked %0d results; status codes seen, one bit per code: %b",
             results_seen, codes_seen);
    if (mismatches == 0 && results_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
